// ----- hw/rtl/sif_pkg.sv -----
// Shared types and constants for the sub-pixel interpolation filter.
`default_nettype none

package sif_pkg;

  // Field and datapath widths
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned COEF_W      = 8;
  localparam int unsigned NUM_SAMPLES = 8;
  localparam int unsigned PROD_W      = SAMPLE_W + COEF_W;
  localparam int unsigned PRE_W       = 40;
  localparam int unsigned HR_W        = 3;
  localparam int unsigned SH_W        = 4;
  localparam int unsigned DEPTH_W     = 4;
  localparam int unsigned PEL_W       = 12;
  localparam int unsigned MODE_W      = 3;

  // Configuration port
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;

  // Fixed-point constants of the filter
  localparam int unsigned INTERNAL_PREC      = 14;
  localparam int unsigned FILTER_PREC        = 6;
  localparam int unsigned INTERNAL_OFFS_LOG2 = 13;

  localparam logic [DEPTH_W-1:0] MIN_DEPTH = 4'd8;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH = 4'd12;

  // Operating modes
  typedef enum logic [MODE_W-1:0] {
    MODE_H_PEL_PEL   = 3'd0,
    MODE_H_PEL_SHORT = 3'd1,
    MODE_V_SHORT_PEL = 3'd2,
    MODE_V_PEL_PEL   = 3'd3,
    MODE_SHORT_PEL   = 3'd4,
    MODE_PEL_SHORT   = 3'd5
  } sif_mode_e;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE         = 2'd0,
    REG_BIT_DEPTH    = 2'd1,
    REG_EIGHT_TAPS   = 2'd2,
    REG_COEFFICIENTS = 2'd3
  } sif_reg_e;

  typedef logic signed [COEF_W-1:0] sif_coef_t;

  // Decoded per-mode normalization controls
  typedef struct packed {
    logic [HR_W-1:0]         pre_shl;
    logic signed [PRE_W-1:0] offset;
    logic [SH_W-1:0]         post_shr;
    logic                    clamp;
    logic [PEL_W-1:0]        pel_max;
    logic                    zero;
  } sif_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/subpel_interpolation_fir.sv -----
// Pipeline: four register stages (multiply, sum, offset, shift).
// Throughput: one item per cycle while the output side accepts; the multiply, sum, offset and shift stages each
// take one item a cycle and stall independently, so bubbles close up under backpressure.
// Reset: asynchronous active-low; clears all stage valid bits and loads the register
// defaults (mode 0, depth 8, eight taps, zero coefficients). No clearing pass.
`default_nettype none

module subpel_interpolation_fir import sif_pkg::*; #(
  parameter int unsigned MAX_TAPS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // sample_0 .. sample_7, 16 bits each, sample_0 in the low bits
  input  logic [NUM_SAMPLES*SAMPLE_W-1:0] s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // filtered_value
  output logic [SAMPLE_W-1:0]             m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_we_i,
  input  logic [CFG_IDX_W-1:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]           cfg_wdata_i
);

  logic signed [SAMPLE_W-1:0] sample [MAX_TAPS];
  sif_coef_t                  coef [MAX_TAPS];
  sif_ctrl_t                  ctrl;
  logic                       mac_valid, norm_ready;
  logic signed [PRE_W-1:0]    mac_sum;
  logic signed [SAMPLE_W-1:0] value;

  // Window unpack
  always_comb begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      sample[i] = s_axis_tdata[SAMPLE_W*i +: SAMPLE_W];
    end
  end

  sif_cfg #(
    .MAX_TAPS (MAX_TAPS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef),
    .ctrl_o      (ctrl)
  );

  sif_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    (sample),
    .coef_i      (coef),
    .out_valid_o (mac_valid),
    .out_ready_i (norm_ready),
    .sum_o       (mac_sum)
  );

  sif_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mac_valid),
    .in_ready_o  (norm_ready),
    .sum_i       (mac_sum),
    .ctrl_i      (ctrl),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .value_o     (value)
  );

  assign m_axis_tdata = value;

`ifndef NO_ASSERTIONS
  // Input side only backs up once the output register holds an item
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output register");

  // Pixel results stay within 0 .. 2^depth-1
  a_pel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ctrl.clamp && !ctrl.zero) |->
      (!m_axis_tdata[SAMPLE_W-1] &&
       (m_axis_tdata <= {{(SAMPLE_W-PEL_W){1'b0}}, ctrl.pel_max})))
    else $error("pixel result out of range");

  // Unused modes give zero
  a_unused_mode_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ctrl.zero) |-> (m_axis_tdata == '0))
    else $error("unused mode gave nonzero result");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/sif_cfg.sv -----
// Configuration registers and mode decode for the interpolation filter.
`default_nettype none

module sif_cfg import sif_pkg::*; #(
  parameter int unsigned MAX_TAPS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output sif_coef_t             coef_o [MAX_TAPS],
  output sif_ctrl_t             ctrl_o
);

  localparam int unsigned CSUM_W = COEF_W + $clog2(MAX_TAPS);
  localparam logic signed [PRE_W-1:0] PRE_ONE   = PRE_W'(1);
  localparam logic signed [PRE_W-1:0] OFFS      = PRE_ONE <<< INTERNAL_OFFS_LOG2;
  localparam logic signed [PRE_W-1:0] OFFS_FILT = OFFS <<< FILTER_PREC;

  logic [MODE_W-1:0]     mode_q;
  logic [DEPTH_W-1:0]    depth_q;
  logic                  eight_q;
  logic [CFG_DATA_W-1:0] coefs_q;

  logic [DEPTH_W-1:0]       depth;
  logic [HR_W-1:0]          hr;
  logic [SH_W-1:0]          shv;
  logic signed [CSUM_W-1:0] csum;
  logic signed [PRE_W-1:0]  round_v;
  sif_ctrl_t                ctrl_d, ctrl_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_H_PEL_PEL;
      depth_q <= MIN_DEPTH;
      eight_q <= 1'b1;
      coefs_q <= '0;
    end else if (cfg_we_i) begin
      case (sif_reg_e'(cfg_idx_i))
        REG_MODE:         mode_q  <= cfg_wdata_i[MODE_W-1:0];
        REG_BIT_DEPTH:    depth_q <= cfg_wdata_i[DEPTH_W-1:0];
        REG_EIGHT_TAPS:   eight_q <= cfg_wdata_i[0];
        REG_COEFFICIENTS: coefs_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective taps: unused lanes are zero, single-sample modes pass sample 0
  always_comb begin
    csum = '0;
    for (int i = 0; i < MAX_TAPS; i++) begin
      logic      used;
      sif_coef_t raw;
      raw  = coefs_q[COEF_W*i +: COEF_W];
      used = eight_q || (i < 4);
      if (used) begin
        csum = csum + CSUM_W'(raw);
      end
      if ((mode_q == MODE_SHORT_PEL) || (mode_q == MODE_PEL_SHORT)) begin
        coef_o[i] = (i == 0) ? sif_coef_t'(1) : '0;
      end else begin
        coef_o[i] = used ? raw : '0;
      end
    end
  end

  // Depth clamp and headroom
  always_comb begin
    if (depth_q < MIN_DEPTH) begin
      depth = MIN_DEPTH;
    end else if (depth_q > MAX_DEPTH) begin
      depth = MAX_DEPTH;
    end else begin
      depth = depth_q;
    end
    hr      = HR_W'(DEPTH_W'(INTERNAL_PREC) - depth);
    shv     = SH_W'(FILTER_PREC) + SH_W'(hr);
    round_v = (PRE_ONE << (shv - SH_W'(1))) + OFFS_FILT;
  end

  // Per-mode offset and shifts
  always_comb begin
    ctrl_d          = '0;
    ctrl_d.pel_max  = PEL_W'((13'(1) << depth) - 13'(1));
    case (mode_q)
      MODE_H_PEL_PEL: begin
        ctrl_d.offset   = PRE_ONE << (hr - HR_W'(1));
        ctrl_d.post_shr = SH_W'(hr);
        ctrl_d.clamp    = 1'b1;
      end
      MODE_H_PEL_SHORT: begin
        ctrl_d.offset   = -(OFFS << (HR_W'(FILTER_PREC) - hr));
        ctrl_d.post_shr = SH_W'(HR_W'(FILTER_PREC) - hr);
      end
      MODE_V_SHORT_PEL: begin
        ctrl_d.offset   = round_v;
        ctrl_d.post_shr = shv;
        ctrl_d.clamp    = 1'b1;
      end
      MODE_V_PEL_PEL: begin
        ctrl_d.pre_shl  = hr;
        ctrl_d.offset   = round_v - (PRE_W'(csum) <<< INTERNAL_OFFS_LOG2);
        ctrl_d.post_shr = shv;
        ctrl_d.clamp    = 1'b1;
      end
      MODE_SHORT_PEL: begin
        ctrl_d.offset   = OFFS + (PRE_ONE << (hr - HR_W'(1)));
        ctrl_d.post_shr = SH_W'(hr);
        ctrl_d.clamp    = 1'b1;
      end
      MODE_PEL_SHORT: begin
        ctrl_d.pre_shl  = hr;
        ctrl_d.offset   = -OFFS;
      end
      default: begin
        ctrl_d.zero = 1'b1;
      end
    endcase
  end

  // Decoded controls, registered, used by the offset and output stages
  always_ff @(posedge clk_i) begin
    ctrl_q <= ctrl_d;
  end

  assign ctrl_o = ctrl_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sif_mac.sv -----
// Multiply and sum stages: one product per tap lane, then the tap sum.
`default_nettype none

module sif_mac import sif_pkg::*; #(
  parameter int unsigned MAX_TAPS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i [MAX_TAPS],
  input  sif_coef_t                  coef_i [MAX_TAPS],
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [PRE_W-1:0]    sum_o
);

  localparam int unsigned SUM_W = PROD_W + $clog2(MAX_TAPS);

  logic                     v1_q, v2_q;
  logic                     en1, en2;
  logic signed [PROD_W-1:0] prod_d [MAX_TAPS];
  logic signed [PROD_W-1:0] prod_q [MAX_TAPS];
  logic signed [SUM_W-1:0]  sum_d, sum_q;

  // Stage enables: a stage loads when it is empty or its item moves on
  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  // Lane products
  always_comb begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      prod_d[i] = PROD_W'(sample_i[i]) * PROD_W'(coef_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      prod_q <= prod_d;
    end
  end

  // Tap sum
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < MAX_TAPS; i++) begin
      sum_d = sum_d + SUM_W'(prod_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      sum_q <= sum_d;
    end
  end

  assign out_valid_o = v2_q;
  assign sum_o       = PRE_W'(sum_q);

endmodule

`default_nettype wire

// ----- hw/rtl/sif_norm.sv -----
// Normalization stages: offset and scale, then shift, truncate and clamp, or zero in unused modes.
`default_nettype none

module sif_norm import sif_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [PRE_W-1:0]    sum_i,
  input  sif_ctrl_t                  ctrl_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] value_o
);

  logic                       v3_q, v4_q;
  logic                       en3, en4;
  logic signed [PRE_W-1:0]    pre_q;
  logic signed [PRE_W-1:0]    shifted;
  logic signed [SAMPLE_W-1:0] t16, max16, value_d, value_q;

  assign en4        = !v4_q || out_ready_i;
  assign en3        = !v3_q || en4;
  assign in_ready_o = en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en3) v3_q <= in_valid_i;
      if (en4) v4_q <= v3_q;
    end
  end

  // Scale up and add rounding and offset terms
  always_ff @(posedge clk_i) begin
    if (en3 && in_valid_i) begin
      pre_q <= (sum_i <<< ctrl_i.pre_shl) + ctrl_i.offset;
    end
  end

  // Floor shift, keep 16 bits, clamp pixel outputs
  always_comb begin
    shifted = pre_q >>> ctrl_i.post_shr;
    t16     = shifted[SAMPLE_W-1:0];
    max16   = {{(SAMPLE_W-PEL_W){1'b0}}, ctrl_i.pel_max};
    if (ctrl_i.zero) begin
      value_d = '0;
    end else if (ctrl_i.clamp && t16 < 0) begin
      value_d = '0;
    end else if (ctrl_i.clamp && t16 > max16) begin
      value_d = max16;
    end else begin
      value_d = t16;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      value_q <= value_d;
    end
  end

  assign out_valid_o = v4_q;
  assign value_o     = value_q;

endmodule

`default_nettype wire

// ----- tb/subpel_interpolation_fir_test.sv -----
// Self-checking testbench for the sub-pixel interpolation FIR stream block.
`timescale 1ns / 100ps

module subpel_interpolation_fir_test import sif_pkg::*; ();

  localparam int unsigned TAPS_MAX     = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam longint      IOFF         = longint'(1) << INTERNAL_OFFS_LOG2;

  // Mode codes that the package leaves unnamed
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  // Sample sources for random windows
  localparam int unsigned SRC_FULL  = 0;
  localparam int unsigned SRC_PEL   = 1;
  localparam int unsigned SRC_SHORT = 2;
  localparam int unsigned SRC_EDGE  = 3;
  localparam int unsigned SRC_MIXED = 4;

  // Tap sets, tap 0 in the low byte
  localparam logic [63:0] COEF_PASS      = 64'h0000_0000_0000_0040;
  localparam logic [63:0] COEF_LUMA_HALF = 64'hFF04_F528_28F5_04FF;
  localparam logic [63:0] COEF_LUMA_QTR  = 64'h0001_FB11_3AF6_04FF;
  localparam logic [63:0] COEF_CHROMA    = 64'h0000_0000_FC24_24FC;
  localparam logic [63:0] COEF_ALL_MAX   = {8{8'h7F}};
  localparam logic [63:0] COEF_ALL_MIN   = {8{8'h80}};

  localparam logic [111:0] JUNK    = {7{16'hA5C3}};
  localparam logic [127:0] ALL_MAX = {8{16'h7FFF}};
  localparam logic [127:0] ALL_MIN = {8{16'h8000}};

  typedef struct packed {
    logic        known;
    logic [15:0] value;
  } preset_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [DEPTH_W-1:0] depth;
    logic               taps;
    logic [63:0]        coef;
    logic [127:0]       win;
    logic               known;
    logic [15:0]        want;
  } dir_row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic [NUM_SAMPLES*SAMPLE_W-1:0] s_axis_tdata;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [SAMPLE_W-1:0]             m_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic                            cfg_we_i;
  logic [CFG_IDX_W-1:0]            cfg_idx_i;
  logic [CFG_DATA_W-1:0]           cfg_wdata_i;

  // Register shadow
  logic [MODE_W-1:0]  cur_mode;
  logic [DEPTH_W-1:0] cur_depth;
  logic               cur_taps;
  logic [63:0]        cur_coef;

  logic [15:0] filtered_q[$];
  preset_t     preset_q[$];
  dir_row_t    dir_tbl[$];

  int unsigned cycle_cnt;
  int unsigned mismatch_cnt;
  int unsigned checked_cnt;
  int unsigned in_stall_cnt;
  int unsigned dir_cnt;
  int unsigned rand_cnt;
  int unsigned setup_cnt;
  int unsigned burst_left;
  int unsigned gap_max;
  int unsigned stall_max;
  int unsigned hold_req;
  int unsigned hold_cnt;
  int unsigned recv_idle;
  logic [15:0] want_val;
  preset_t     pre;
  dir_row_t    row;

  subpel_interpolation_fir #(
    .MAX_TAPS(TAPS_MAX)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Filtered value of one window under the given register values
  function automatic logic [15:0] interp_filter(input logic [127:0] win,
                                                input logic [MODE_W-1:0] m,
                                                input logic [DEPTH_W-1:0] dcfg,
                                                input logic t,
                                                input logic [63:0] cf);
    int unsigned       dd, hr, ntaps, sh, i;
    longint            psum, csum, v, pel_max;
    logic signed [15:0] smp, s0, t16;
    logic signed [7:0]  cof;
    dd = dcfg;
    if (dd < 8) dd = 8;
    if (dd > 12) dd = 12;
    hr = INTERNAL_PREC - dd;
    ntaps = t ? TAPS_MAX : 4;
    s0 = win[15:0];
    psum = 0;
    csum = 0;
    for (i = 0; i < ntaps; i++) begin
      smp = win[16*i +: 16];
      cof = cf[8*i +: 8];
      psum += longint'(smp) * longint'(cof);
      csum += longint'(cof);
    end
    case (m)
      MODE_H_PEL_PEL: v = (psum + (longint'(1) << (hr - 1))) >>> hr;
      MODE_H_PEL_SHORT: begin
        sh = FILTER_PREC - hr;
        v = (psum - (IOFF << sh)) >>> sh;
      end
      MODE_V_SHORT_PEL, MODE_V_PEL_PEL: begin
        sh = FILTER_PREC + hr;
        // pel input is lifted to intermediate scale before the taps
        if (m == MODE_V_PEL_PEL) psum = (psum <<< hr) - csum * IOFF;
        v = (psum + (longint'(1) << (sh - 1)) + (IOFF << FILTER_PREC)) >>> sh;
      end
      MODE_SHORT_PEL: v = (longint'(s0) + IOFF + (longint'(1) << (hr - 1))) >>> hr;
      MODE_PEL_SHORT: v = (longint'(s0) <<< hr) - IOFF;
      default: v = 0;
    endcase
    t16 = v[15:0];
    v = t16;
    // pixel outputs clamp to the depth range
    if (m == MODE_H_PEL_PEL || m == MODE_V_SHORT_PEL || m == MODE_V_PEL_PEL ||
        m == MODE_SHORT_PEL) begin
      pel_max = (longint'(1) << dd) - 1;
      if (v < 0) v = 0;
      if (v > pel_max) v = pel_max;
    end
    return v[15:0];
  endfunction

  // Random window, mostly shaped for the input kind of the mode
  function automatic logic [127:0] rand_window(input logic [MODE_W-1:0] m,
                                               input logic [DEPTH_W-1:0] dcfg);
    logic [127:0] w;
    logic [15:0]  s;
    int unsigned  dd, src, k, i;
    dd = dcfg;
    if (dd < 8) dd = 8;
    if (dd > 12) dd = 12;
    if ($urandom_range(0, 9) < 7)
      src = (m == MODE_V_SHORT_PEL || m == MODE_SHORT_PEL) ? SRC_SHORT : SRC_PEL;
    else
      src = SRC_MIXED;
    for (i = 0; i < NUM_SAMPLES; i++) begin
      k = (src == SRC_MIXED) ? $urandom_range(SRC_FULL, SRC_EDGE) : src;
      case (k)
        SRC_PEL:   s = 16'($urandom_range(0, (1 << dd) - 1));
        SRC_SHORT: s = 16'($urandom_range(0, 16383) - 8192);
        SRC_EDGE: begin
          case ($urandom_range(0, 3))
            0:       s = 16'h7FFF;
            1:       s = 16'h8000;
            2:       s = 16'h0000;
            default: s = 16'hFFFF;
          endcase
        end
        default:   s = 16'($urandom);
      endcase
      w[16*i +: 16] = s;
    end
    return w;
  endfunction

  function automatic logic [63:0] rand_coef();
    case ($urandom_range(0, 5))
      0:       return COEF_LUMA_HALF;
      1:       return COEF_LUMA_QTR;
      2:       return {$urandom, COEF_CHROMA[31:0]};
      3:       return COEF_ALL_MAX;
      4:       return COEF_ALL_MIN;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One register write; the caller lowers the write enable
  task automatic cfg_write(input sif_reg_e idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_MODE:         cur_mode  = val[MODE_W-1:0];
      REG_BIT_DEPTH:    cur_depth = val[DEPTH_W-1:0];
      REG_EIGHT_TAPS:   cur_taps  = val[0];
      REG_COEFFICIENTS: cur_coef  = val;
      default: ;
    endcase
  endtask

  // Drain the pipe, then load a new setting; upper bits carry junk
  task automatic apply_cfg(input logic [MODE_W-1:0] m, input logic [DEPTH_W-1:0] d,
                           input logic t, input logic [63:0] c, input bit every);
    logic [63:0] junk;
    s_axis_tvalid <= 1'b0;
    // let the last accepted item reach the expectation store first
    @(posedge clk_i);
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    junk = {$urandom, $urandom};
    if (every || m != cur_mode) cfg_write(REG_MODE, {junk[63:MODE_W], m});
    if (every || d != cur_depth) cfg_write(REG_BIT_DEPTH, {junk[63:DEPTH_W], d});
    if (every || t != cur_taps) cfg_write(REG_EIGHT_TAPS, {junk[63:1], t});
    if (every || c != cur_coef) cfg_write(REG_COEFFICIENTS, c);
    cfg_we_i <= 1'b0;
    setup_cnt++;
  endtask

  // Offer one window until taken, then maybe pause between bursts
  task automatic send_window(input logic [127:0] w, input logic k, input logic [15:0] v);
    int unsigned gap;
    preset_q.push_back(preset_t'{k, v});
    s_axis_tdata  <= w;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if (gap_max != 0) begin
        gap = $urandom_range(0, gap_max);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  task automatic add_row(input logic [MODE_W-1:0] m, input logic [DEPTH_W-1:0] d,
                         input logic t, input logic [63:0] c, input logic [127:0] w,
                         input logic k, input logic [15:0] v);
    dir_tbl.push_back(dir_row_t'{m, d, t, c, w, k, v});
  endtask

  // Result checker and expectation store
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected filtered value, expected none, actual %h",
                   $time, m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want_val = filtered_q.pop_front();
          checked_cnt++;
          if (m_axis_tdata !== want_val) begin
            $display("%0t: filtered_value mismatch, expected %h, actual %h",
                     $time, want_val, m_axis_tdata);
            mismatch_cnt++;
          end
        end
      end
      if (s_axis_tvalid && !s_axis_tready) in_stall_cnt++;
      if (s_axis_tvalid && s_axis_tready) begin
        if (preset_q.size() != 0)
          pre = preset_q.pop_front();
        else
          pre = preset_t'{1'b0, 16'h0};
        if (pre.known)
          filtered_q.push_back(pre.value);
        else
          filtered_q.push_back(interp_filter(s_axis_tdata, cur_mode, cur_depth,
                                             cur_taps, cur_coef));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d values outstanding",
               cycle_cnt, filtered_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Output side: random ready runs and stalls, plus a long hold on request
  initial begin
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_req != 0) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 0;
        hold_cnt++;
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        if (stall_max != 0) begin
          recv_idle = $urandom_range(0, stall_max);
          if (recv_idle != 0) begin
            m_axis_tready <= 1'b0;
            repeat (recv_idle) @(posedge clk_i);
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_MODE;
    cfg_wdata_i   <= '0;
    cur_mode      = MODE_H_PEL_PEL;
    cur_depth     = MIN_DEPTH;
    cur_taps      = 1'b1;
    cur_coef      = '0;
    burst_left    = 0;
    gap_max       = 2;
    stall_max     = 3;
    hold_req      = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed windows: reset defaults, pass-through, extremes, every mode
    add_row(MODE_H_PEL_PEL,   4'd8,  1'b1, 64'h0,          ALL_MAX,           1'b1, 16'h0000);
    add_row(MODE_H_PEL_PEL,   4'd8,  1'b1, COEF_PASS,      {JUNK, 16'd200},   1'b1, 16'd200);
    add_row(MODE_H_PEL_PEL,   4'd8,  1'b1, COEF_PASS,      {JUNK, 16'd300},   1'b1, 16'd255);
    add_row(MODE_H_PEL_PEL,   4'd8,  1'b1, COEF_PASS,      {JUNK, 16'hFFFB},  1'b1, 16'h0000);
    add_row(MODE_H_PEL_PEL,   4'd8,  1'b1, COEF_ALL_MAX,   ALL_MAX,           1'b0, 16'h0);
    add_row(MODE_H_PEL_PEL,   4'd8,  1'b1, COEF_ALL_MIN,   ALL_MAX,           1'b0, 16'h0);
    // four taps: high samples and taps must not count
    add_row(MODE_H_PEL_PEL,   4'd12, 1'b0, COEF_ALL_MIN,   ALL_MIN,           1'b0, 16'h0);
    add_row(MODE_H_PEL_SHORT, 4'd8,  1'b0, {32'h7F7F7F7F, COEF_CHROMA[31:0]},
            {64'h7FFF_8000_7FFF_8000, 64'h0000_00FF_0080_0010},               1'b0, 16'h0);
    add_row(MODE_H_PEL_SHORT, 4'd12, 1'b1, COEF_LUMA_HALF, {8{16'h0FFF}},     1'b0, 16'h0);
    add_row(MODE_H_PEL_SHORT, 4'd10, 1'b1, COEF_ALL_MAX,   ALL_MIN,           1'b0, 16'h0);
    add_row(MODE_V_SHORT_PEL, 4'd8,  1'b1, COEF_LUMA_HALF, {8{16'hE000}},     1'b0, 16'h0);
    add_row(MODE_V_SHORT_PEL, 4'd12, 1'b1, COEF_ALL_MAX,   ALL_MAX,           1'b0, 16'h0);
    add_row(MODE_V_PEL_PEL,   4'd8,  1'b0, COEF_CHROMA,
            {64'h0, 64'h00FF_0000_00FF_0080},                                 1'b0, 16'h0);
    add_row(MODE_V_PEL_PEL,   4'd12, 1'b1, COEF_ALL_MIN,   ALL_MAX,           1'b0, 16'h0);
    add_row(MODE_SHORT_PEL,   4'd8,  1'b1, COEF_ALL_MIN,   {JUNK, 16'h7FFF},  1'b1, 16'd255);
    add_row(MODE_SHORT_PEL,   4'd12, 1'b1, COEF_ALL_MIN,   {JUNK, 16'h8000},  1'b1, 16'h0000);
    add_row(MODE_SHORT_PEL,   4'd12, 1'b1, COEF_ALL_MIN,   {JUNK, 16'h0000},  1'b1, 16'h0800);
    add_row(MODE_PEL_SHORT,   4'd8,  1'b1, COEF_ALL_MIN,   {JUNK, 16'h0000},  1'b1, 16'hE000);
    add_row(MODE_PEL_SHORT,   4'd8,  1'b1, COEF_ALL_MIN,   {JUNK, 16'h7FFF},  1'b1, 16'hDFC0);
    add_row(MODE_PEL_SHORT,   4'd12, 1'b0, COEF_ALL_MIN,   {JUNK, 16'h8000},  1'b0, 16'h0);
    // unused mode codes give zero
    add_row(MODE_SPARE_6,     4'd8,  1'b1, COEF_ALL_MIN,   ALL_MAX,           1'b1, 16'h0000);
    add_row(MODE_SPARE_7,     4'd10, 1'b0, COEF_ALL_MIN,   ALL_MAX,           1'b1, 16'h0000);
    // depth codes outside 8..12 saturate
    add_row(MODE_PEL_SHORT,   4'd0,  1'b1, COEF_ALL_MIN,   {JUNK, 16'h0001},  1'b0, 16'h0);
    add_row(MODE_PEL_SHORT,   4'd15, 1'b1, COEF_ALL_MIN,   {JUNK, 16'h0001},  1'b0, 16'h0);
    add_row(MODE_H_PEL_PEL,   4'd7,  1'b1, COEF_PASS,      {JUNK, 16'd300},   1'b0, 16'h0);

    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      if (row.mode != cur_mode || row.depth != cur_depth || row.taps != cur_taps ||
          row.coef != cur_coef)
        apply_cfg(row.mode, row.depth, row.taps, row.coef, 1'b0);
      send_window(row.win, row.known, row.want);
      dir_cnt++;
    end

    // Random phases, each with its own setting and idling style
    for (int p = 0; p < PHASES; p++) begin
      logic [MODE_W-1:0]  rm;
      logic [DEPTH_W-1:0] rd;
      int unsigned        pick;
      pick = $urandom_range(0, 15);
      rm = MODE_W'((p < 6) ? p : ((pick < 14) ? pick % 6 : pick - 8));
      pick = $urandom_range(0, 9);
      if (p == 0)
        rd = MIN_DEPTH;
      else if (p == 1)
        rd = MAX_DEPTH;
      else
        rd = DEPTH_W'((pick < 8) ? MIN_DEPTH + pick % 5 : $urandom_range(0, 15));
      apply_cfg(rm, rd, (p < 2) ? p[0] : 1'($urandom_range(0, 1)), rand_coef(), 1'b1);
      case (p % 4)
        0: begin gap_max = 0; stall_max = 0;  end
        1: begin gap_max = 3; stall_max = 2;  end
        2: begin gap_max = 8; stall_max = 10; end
        default: begin gap_max = 2; stall_max = 6; end
      endcase
      // long output hold while windows keep coming
      if (p == 2) hold_req = 1;
      repeat (PHASE_ITEMS) begin
        send_window(rand_window(cur_mode, cur_depth), 1'b0, 16'h0);
        rand_cnt++;
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d directed and %0d random windows over %0d register setups;",
             dir_cnt, rand_cnt, setup_cnt);
    $display("%0d values compared, %0d long output holds, %0d input stall cycles.",
             checked_cnt, hold_cnt, in_stall_cnt);
    if (mismatch_cnt == 0 && preset_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
